FILE: hdl/rcfe_pkg.sv
package rcfe_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W       = $clog2(NUM_CHANNELS + 2);
  localparam int VAL_W        = 12;
  localparam int PADDR_W      = 3;

  localparam logic [VAL_W-1:0] RESET_VALUE   = 12'd1000;
  localparam logic [VAL_W-1:0] MIN_RESET     = 12'd1000;
  localparam logic [VAL_W-1:0] MAX_RESET     = 12'd2000;
  localparam logic [VAL_W-1:0] BYTE_OFFSET   = 12'd400;
  localparam logic [12:0]      RECIP_10      = 13'd6554;
  localparam logic [7:0]       FRAME_START   = 8'h0F;
  localparam logic [7:0]       FRAME_END     = 8'h00;

  localparam logic REG_MIN_VALUE = 1'b0;
  localparam logic REG_MAX_VALUE = 1'b1;

  typedef struct packed {
    logic [5:0]         channel_index;
    logic signed [15:0] pulse_value;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_payload_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

FILE: hdl/rcfe_regs.sv
module rcfe_regs
  import rcfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output logic [VAL_W-1:0]   min_value,
  output logic [VAL_W-1:0]   max_value
);

  logic [VAL_W-1:0] min_r;
  logic [VAL_W-1:0] max_r;
  logic             wr_go;
  logic             reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_go      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_RESET;
      max_r <= MAX_RESET;
    end else if (wr_go) begin
      unique case (reg_sel)
        REG_MIN_VALUE: min_r <= cfg_pwdata[VAL_W-1:0];
        REG_MAX_VALUE: max_r <= cfg_pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_VALUE: cfg_prdata = {{(32-VAL_W){1'b0}}, min_r};
      REG_MAX_VALUE: cfg_prdata = {{(32-VAL_W){1'b0}}, max_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign min_value = min_r;
  assign max_value = max_r;

endmodule

FILE: hdl/rcfe_chan_mem.sv
module rcfe_chan_mem
  import rcfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0]        mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [VAL_W-1:0]        rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : RESET_VALUE;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/rcfe_frame_seq.sv
module rcfe_frame_seq
  import rcfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_payload_t      in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_payload_t     out_data,
  input  logic [VAL_W-1:0] min_value,
  input  logic [VAL_W-1:0] max_value,
  output mem_req_t         mem_req,
  input  logic [VAL_W-1:0] mem_rd_data
);

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAN  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_CHANNELS + 1);

  logic              busy_r, busy_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              pend_r, pend_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_payload_t      out_data_r, out_data_nxt;

  logic              in_acc, hit;
  logic              out_free, move, issue;
  logic signed [16:0] v_ext, min_ext, max_ext;
  logic [VAL_W-1:0]  clamped;
  logic [SLOT_W-1:0] slot_m1;
  logic [1:0]        issue_kind;
  logic [VAL_W-1:0]  diff;
  logic [24:0]       prod;
  logic [8:0]        quot;
  logic [7:0]        chan_byte;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign hit      = in_acc && (in_data.channel_index < 6'(NUM_CHANNELS));

  assign v_ext   = {in_data.pulse_value[15], in_data.pulse_value};
  assign min_ext = {5'b0, min_value};
  assign max_ext = {5'b0, max_value};

  always_comb begin
    if (v_ext > max_ext) begin
      clamped = max_value;
    end else if (v_ext < min_ext) begin
      clamped = min_value;
    end else begin
      clamped = in_data.pulse_value[VAL_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign move     = pend_r && out_free;
  assign issue    = busy_r && (!pend_r || move);
  assign slot_m1  = slot_r - SLOT_W'(1);

  always_comb begin
    if (slot_r == '0) begin
      issue_kind = KIND_START;
    end else if (slot_r == SLOT_LAST) begin
      issue_kind = KIND_END;
    end else begin
      issue_kind = KIND_CHAN;
    end
  end

  always_comb begin
    mem_req.wr_en   = hit;
    mem_req.wr_addr = in_data.channel_index[ADDR_W-1:0];
    mem_req.wr_data = clamped;
    mem_req.rd_en   = issue && (issue_kind == KIND_CHAN);
    mem_req.rd_addr = slot_m1[ADDR_W-1:0];
  end

  // (stored - 400) / 10 by reciprocal multiply, saturated to a byte
  assign diff = mem_rd_data - BYTE_OFFSET;
  assign prod = 25'(diff) * 25'(RECIP_10);
  assign quot = prod[24:16];

  always_comb begin
    if (mem_rd_data < BYTE_OFFSET) begin
      chan_byte = 8'd0;
    end else if (quot > 9'd255) begin
      chan_byte = 8'hFF;
    end else begin
      chan_byte = quot[7:0];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    slot_nxt      = slot_r;
    pend_nxt      = pend_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (move) begin
      out_valid_nxt = 1'b1;
      pend_nxt      = 1'b0;
      case (kind_r)
        KIND_START: out_data_nxt = '{frame_byte: FRAME_START, last_byte: 1'b0};
        KIND_END:   out_data_nxt = '{frame_byte: FRAME_END,   last_byte: 1'b1};
        default:    out_data_nxt = '{frame_byte: chan_byte,   last_byte: 1'b0};
      endcase
    end
    if (issue) begin
      pend_nxt = 1'b1;
      kind_nxt = issue_kind;
      if (slot_r == SLOT_LAST) begin
        slot_nxt = '0;
        busy_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
    if (hit) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= '0;
      pend_r      <= 1'b0;
      kind_r      <= KIND_START;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      pend_r      <= pend_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/rc_channel_frame_encoder.sv
// An in-range input beat goes through busy_r/slot_r and pend_r/kind_r; out_valid_r then
//   shows 0x0F. It stalls the input for a frame, paced by the single read port of the
//   channel store, one entry per cycle unless out_stall holds; out-of-range: no stall.
// Reset: min 1000, max 2000, every channel reads 1000 (per-entry valid bits), outputs idle.
module rc_channel_frame_encoder
  import rcfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_payload_t        in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_payload_t       out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [VAL_W-1:0] min_value;
  logic [VAL_W-1:0] max_value;
  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rd_data;

  rcfe_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .min_value   (min_value),
    .max_value   (max_value)
  );

  rcfe_chan_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  rcfe_frame_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .min_value   (min_value),
    .max_value   (max_value),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> out_data.frame_byte == FRAME_END)
    else $error("last beat is not the end byte");

  a_hit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.channel_index < 6'(NUM_CHANNELS)) |=> in_stall)
    else $error("in-range beat did not start a frame");

  a_miss_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.channel_index >= 6'(NUM_CHANNELS)) |=> !in_stall)
    else $error("out-of-range beat started a frame");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> !mem_req.rd_en)
    else $error("store write overlaps frame read");

endmodule

FILE: tb/rc_channel_frame_encoder_test.sv
`timescale 1ns / 1ps

module rc_channel_frame_encoder_test;
  import rcfe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_payload_t        in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_payload_t       out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  rc_channel_frame_encoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  in_payload_t  pending_beats[$];
  out_payload_t frame_expected[$];

  logic [VAL_W-1:0] clamp_floor = MIN_RESET;
  logic [VAL_W-1:0] clamp_ceil  = MAX_RESET;
  logic [VAL_W-1:0] chan_store[NUM_CHANNELS];

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   error_count = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < NUM_CHANNELS; i++) chan_store[i] = RESET_VALUE;
  end

  function automatic logic [7:0] store_to_byte(logic [VAL_W-1:0] stored);
    int q;
    if (stored < BYTE_OFFSET) return 8'd0;
    q = (int'(stored) - int'(BYTE_OFFSET)) / 10;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  // Update one channel and queue the whole frame it triggers.
  function automatic void encode_update(in_payload_t beat);
    int           v;
    out_payload_t b;
    v = int'($signed(beat.pulse_value));
    if (int'(beat.channel_index) >= NUM_CHANNELS) return;
    if (v > int'(clamp_ceil)) chan_store[beat.channel_index] = clamp_ceil;
    else if (v < int'(clamp_floor)) chan_store[beat.channel_index] = clamp_floor;
    else chan_store[beat.channel_index] = VAL_W'(v);
    b.frame_byte = FRAME_START;
    b.last_byte = 1'b0;
    frame_expected.push_back(b);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      b.frame_byte = store_to_byte(chan_store[i]);
      frame_expected.push_back(b);
    end
    b.frame_byte = FRAME_END;
    b.last_byte = 1'b1;
    frame_expected.push_back(b);
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Monitor, predictor hookup and watchdog.
  always @(posedge clk) begin
    out_payload_t want;
    logic         out_fire;
    in_fire = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_fire = 1'b1;
        encode_update(in_data);
      end
      if (out_valid && !out_stall) begin
        out_fire = 1'b1;
        if (frame_expected.size() == 0) begin
          note_mismatch("unexpected beat", out_data.frame_byte, -1);
        end else begin
          want = frame_expected.pop_front();
          if (out_data.frame_byte !== want.frame_byte)
            note_mismatch("frame_byte", out_data.frame_byte, want.frame_byte);
          if (out_data.last_byte !== want.last_byte)
            note_mismatch("last_byte", out_data.last_byte, want.last_byte);
        end
      end
      if (in_fire || out_fire || (cfg_psel && cfg_penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("rc_channel_frame_encoder test failed");
        $finish;
      end
    end
  end

  // Input driver.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_beats.size() == 0 || $urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= pending_beats.pop_front();
      end
    end
  end

  // Result-side stall, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic add_beat(int ch, int pulse);
    in_payload_t b;
    b.channel_index = 6'(ch);
    b.pulse_value = 16'(pulse);
    pending_beats.push_back(b);
  endtask

  task automatic add_random(int count);
    int ch;
    int pulse;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) ch = $urandom_range(0, NUM_CHANNELS - 1);
      else ch = $urandom_range(NUM_CHANNELS, 63);
      case ($urandom_range(0, 3))
        0: pulse = int'($urandom_range(0, 65535)) - 32768;
        1, 2: pulse = $urandom_range(300, 3100);
        default: begin
          pulse = ($urandom_range(0, 1) != 0) ? int'(clamp_floor) : int'(clamp_ceil);
          pulse += int'($urandom_range(0, 2)) - 1;
        end
      endcase
      add_beat(ch, pulse);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_beats.size() != 0 || in_valid || frame_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Called at a falling edge with the block idle.
  task automatic cfg_write(logic reg_sel, logic [VAL_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= {20'($urandom), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_sel == REG_MIN_VALUE) clamp_floor = value;
    else clamp_ceil = value;
    @(negedge clk);
  endtask

  task automatic set_limits(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    wait_for_drain();
    cfg_write(REG_MIN_VALUE, lo);
    cfg_write(REG_MAX_VALUE, hi);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: boundaries, extremes, ignored channels
    tx_idle_pct = 6;
    rx_idle_pct = 56;
    add_beat(0, 1500);
    add_beat(7, 32767);
    add_beat(1, -32768);
    add_beat(63, 1234);
    add_beat(NUM_CHANNELS, 1500);
    add_beat(2, 2000);
    add_beat(3, 2001);
    add_beat(4, 1000);
    add_beat(5, 999);
    add_beat(6, 0);
    add_beat(6, -1);
    add_beat(32, -1);
    add_beat(7, 1009);

    // open limits: channel byte saturates low and high
    set_limits(12'd0, 12'd4095);
    add_beat(0, 399);
    add_beat(1, 0);
    add_beat(2, -5);
    add_beat(3, 4095);
    add_beat(4, 32767);
    add_beat(5, 2950);
    add_beat(6, 2960);
    add_beat(7, 410);
    add_random(30);

    set_limits(12'd400, 12'd2950);
    add_random(90);

    // inverted limits: ceiling checked first
    tx_idle_pct = 56;
    rx_idle_pct = 6;
    set_limits(12'd2950, 12'd400);
    add_beat(0, 5000);
    add_beat(1, 401);
    add_beat(2, 100);
    add_random(70);

    set_limits(12'($urandom_range(400, 2950)), 12'($urandom_range(400, 2950)));
    add_random(50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_limits(12'($urandom_range(400, 2950)), 12'($urandom_range(400, 2950)));
    add_random(60);
    @(posedge clk);
    hold_request = 1'b1;
    wait_for_drain();

    set_limits(12'($urandom_range(400, 1500)), 12'($urandom_range(1500, 2950)));
    add_random(45);
    wait_for_drain();

    repeat (20) @(posedge clk);
    if (error_count == 0 && frame_expected.size() == 0) begin
      $display("rc_channel_frame_encoder test passed");
    end else begin
      $display("rc_channel_frame_encoder test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rcfe_pkg.sv
hdl/rcfe_regs.sv
hdl/rcfe_chan_mem.sv
hdl/rcfe_frame_seq.sv
hdl/rc_channel_frame_encoder.sv
tb/rc_channel_frame_encoder_test.sv
